// ----- rtl/unsigned_restoring_divider_macros.svh -----
// Assertion macros used by the checker file of the divider.
`ifndef UNSIGNED_RESTORING_DIVIDER_MACROS_SVH
`define UNSIGNED_RESTORING_DIVIDER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define URD_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("divider check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define URD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |-> ##dly (cons)) else $error("divider check failed");

`endif

// ----- rtl/urd_pkg.sv -----
`default_nettype none

package urd_pkg;

	// Width of every field on the ports.
	localparam int unsigned DATA_W = 32;

	// Default operand width used by the arithmetic.
	localparam int unsigned WIDTH_DEFAULT = 32;

	// Input item: one division request.
	typedef struct packed {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} operands_t;

	// Result item: quotient and remainder.
	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/urd_cell.sv -----
`default_nettype none

// One restoring step: shift in the next dividend bit, try the subtraction,
// keep or restore the partial remainder, and register the result.
module urd_cell import urd_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire logic [WIDTH-1:0] rem_in,
	input  wire logic [WIDTH-1:0] dq_in,
	input  wire logic [WIDTH-1:0] div_in,
	output logic                  valid_out,
	output logic      [WIDTH-1:0] rem_out,
	output logic      [WIDTH-1:0] dq_out,
	output logic      [WIDTH-1:0] div_out
);

	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] diff;
	logic             borrow;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] dq_next;

	logic             valid_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dq_q;
	logic [WIDTH-1:0] div_q;

	// Trial subtraction; the top bit of the difference is the borrow.
	always_comb begin
		shifted  = {rem_in, dq_in[WIDTH-1]};
		diff     = {1'b0, shifted} - {2'b00, div_in};
		borrow   = diff[WIDTH+1];
		// The kept value is below the divisor, so WIDTH bits hold it.
		rem_next = borrow ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
		// Dividend bits move out at the top while quotient bits enter below.
		dq_next  = {dq_in[WIDTH-2:0], ~borrow};
	end

	// Only the valid flag needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	// Payload moves on every cycle.
	always_ff @(posedge clk) begin
		rem_q <= rem_next;
		dq_q  <= dq_next;
		div_q <= div_in;
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign dq_out    = dq_q;
	assign div_out   = div_q;

endmodule

`default_nettype wire

// ----- rtl/unsigned_restoring_divider.sv -----
// Unsigned restoring divider. A division is requested by raising start with
// the operands; busy is always low, so a new division may start on every
// clock cycle. Each result appears on result with done high for exactly one
// cycle, once its request has passed the chain of WIDTH cells, one per quotient
// bit, each registered, in the order the requests came; the receiver cannot
// stall and must take it in that cycle. A zero divisor gives a quotient of
// all ones and a remainder equal to the dividend.
// Operand bits above WIDTH are ignored and result bits above WIDTH are zero.
`default_nettype none

module unsigned_restoring_divider import urd_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire operands_t operands,
	output logic           done,
	output result_t        result
);

	logic             stage_valid [WIDTH+1];
	logic [WIDTH-1:0] stage_rem   [WIDTH+1];
	logic [WIDTH-1:0] stage_dq    [WIDTH+1];
	logic [WIDTH-1:0] stage_div   [WIDTH+1];

	// The chain always advances, so a transfer is never refused.
	assign busy = 1'b0;

	// Head of the chain: partial remainder starts at zero.
	assign stage_valid[0] = start;
	assign stage_rem[0]   = '0;
	assign stage_dq[0]    = operands.dividend[WIDTH-1:0];
	assign stage_div[0]   = operands.divisor[WIDTH-1:0];

	// One cell per quotient bit, most significant bit first.
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		urd_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (stage_valid[i]),
			.rem_in   (stage_rem[i]),
			.dq_in    (stage_dq[i]),
			.div_in   (stage_div[i]),
			.valid_out(stage_valid[i+1]),
			.rem_out  (stage_rem[i+1]),
			.dq_out   (stage_dq[i+1]),
			.div_out  (stage_div[i+1])
		);
	end

	// Tail of the chain drives the result ports directly.
	assign done             = stage_valid[WIDTH];
	assign result.quotient  = DATA_W'(stage_dq[WIDTH]);
	assign result.remainder = DATA_W'(stage_rem[WIDTH]);

endmodule

`default_nettype wire

// ----- rtl/urd_checker.sv -----
`default_nettype none
`include "unsigned_restoring_divider_macros.svh"

// Port-level checks on the divider.
module urd_checker import urd_pkg::*; #(
	parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire operands_t operands,
	input wire logic      done,
	input wire result_t   result
);

	logic             xfer;
	logic             div_zero;
	logic [WIDTH-1:0] num_w;
	logic [WIDTH-1:0] den_w;
	logic [WIDTH-1:0] quo_w;
	logic [WIDTH-1:0] rem_w;

	// Operand and result bits that the arithmetic works on.
	assign xfer     = start && !busy;
	assign num_w    = operands.dividend[WIDTH-1:0];
	assign den_w    = operands.divisor[WIDTH-1:0];
	assign quo_w    = result.quotient[WIDTH-1:0];
	assign rem_w    = result.remainder[WIDTH-1:0];
	assign div_zero = (den_w == '0);

	// The divider never refuses a transfer.
	`URD_ASSERT_ALWAYS(a_never_busy, clk, arst_n, busy == 1'b0)

	// Every accepted request is later answered with done high.
	`URD_ASSERT_DELAY(a_latency, clk, arst_n, xfer, WIDTH, done)

	// A zero divisor yields an all-ones quotient and the dividend as remainder.
	`URD_ASSERT_DELAY(a_div_zero, clk, arst_n, xfer && div_zero, WIDTH, (quo_w == '1) && (rem_w == $past(num_w, WIDTH)))

	// Otherwise the remainder lies below the divisor.
	`URD_ASSERT_DELAY(a_rem_small, clk, arst_n, xfer && !div_zero, WIDTH, rem_w < $past(den_w, WIDTH))

endmodule

bind unsigned_restoring_divider urd_checker #(.WIDTH(WIDTH)) u_urd_checker (.*);

`default_nettype wire
